// ===== src/rpt_pkg.sv =====
// Shared types and constants for the RC PWM throttle decoder.
package rpt_pkg;

	// Field widths.
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned CAP_W  = 16;
	localparam int unsigned THR_W  = 10;
	localparam int unsigned DUTY_W = 16;
	localparam int unsigned FREQ_W = 20;
	localparam int unsigned CLK_W  = 27;
	localparam int unsigned PRE_W  = 8;
	localparam int unsigned CFG_W  = 27;
	localparam int unsigned IDX_W  = 2;

	// Serial divider widths: the dividend holds the clock rate, the divisor
	// holds (prescaler + 1) * period, truncated to its 24 bits.
	localparam int unsigned NUM_W = 27;
	localparam int unsigned DEN_W = 24;
	localparam int unsigned CNT_W = 5;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_PERIOD  = 2'd0,
		CMD_WIDTH   = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_CLOCK_HZ  = 2'd0,
		REG_PRESCALER = 2'd1,
		REG_MIN_DUTY  = 2'd2,
		REG_MAX_DUTY  = 2'd3
	} reg_idx_t;

	// Qualification limits.
	localparam logic [FREQ_W-1:0] FREQ_MAX    = 20'hFFFFF;
	localparam logic [FREQ_W-1:0] FREQ_LOW    = 20'd30;
	localparam logic [FREQ_W-1:0] FREQ_HIGH   = 20'd400;
	localparam logic [CAP_W-1:0]  WIDTH_MIN   = 16'd1000;
	localparam logic [CAP_W-1:0]  WIDTH_MAX   = 16'd3000;
	localparam logic [CAP_W-1:0]  WIDTH_CLAMP = 16'd2000;
	localparam logic [THR_W-1:0]  THR_SCALE   = 10'd1000;

	// Reset values of the configuration registers.
	localparam logic [CLK_W-1:0]  CLOCK_HZ_RST  = 27'd35000000;
	localparam logic [PRE_W-1:0]  PRESCALER_RST = 8'd32;
	localparam logic [DUTY_W-1:0] MIN_DUTY_RST  = 16'd50;
	localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 16'd1000;

endpackage

// ===== src/rc_pwm_throttle_decoder.sv =====
// Top level of the RC PWM throttle decoder.
//
//   Channel   Handshake              Payload
//   cfg       cfg_we                 cfg_index, cfg_data
//   in        in_valid / in_stall    command, capture_value
//   out       out_valid / out_stall  throttle, duty, frequency
//
// A period request takes one pass of the bit-serial divider (27 quotient
// bits), a zero period none. A width request that reaches qualification
// takes two divider passes, other widths one pass; timeouts take none.
// Reset clears the stored frequency, throttle and duty and loads the default
// configuration. A new request is taken while the last result waits in the
// output register; a finished result waits for that register to empty.
module rc_pwm_throttle_decoder
	import rpt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [CAP_W-1:0]  capture_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [THR_W-1:0]  throttle,
	output logic [DUTY_W-1:0] duty,
	output logic [FREQ_W-1:0] frequency
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FREQ,
		ST_DEADBAND,
		ST_DUTY_START,
		ST_DUTY,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CLK_W-1:0]  clock_hz_q;
	logic [PRE_W-1:0]  prescaler_q;
	logic [DUTY_W-1:0] min_duty_q;
	logic [DUTY_W-1:0] max_duty_q;
	logic [FREQ_W-1:0] freq_q;
	logic [THR_W-1:0]  thr_q;
	logic [DUTY_W-1:0] duty_q;
	logic [THR_W-1:0]  width_q;
	logic              out_valid_q;
	logic [THR_W-1:0]  throttle_q;
	logic [DUTY_W-1:0] duty_out_q;
	logic [FREQ_W-1:0] frequency_q;

	logic              accept;
	logic              out_free;
	logic              in_window;
	logic              width_ok;
	logic [CAP_W-1:0]  width_clamped;
	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Width qualification terms.
	assign in_window     = (freq_q > FREQ_LOW) && (freq_q < FREQ_HIGH);
	assign width_ok      = (capture_value >= WIDTH_MIN) && (capture_value <= WIDTH_MAX);
	assign width_clamped = (capture_value > WIDTH_CLAMP) ? WIDTH_CLAMP : capture_value;

	// Divider operand selection for the three divisions.
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_IDLE: begin
				if (command == CMD_PERIOD) begin
					div_start = accept && (capture_value != '0);
					div_num   = NUM_W'(clock_hz_q);
					div_den   = DEN_W'({1'b0, prescaler_q} + 9'd1) * DEN_W'(capture_value);
				end else begin
					div_start = accept && (command == CMD_WIDTH) && in_window && width_ok
						&& (max_duty_q != '0);
					div_num   = NUM_W'(min_duty_q) * NUM_W'(THR_SCALE);
					div_den   = DEN_W'(max_duty_q);
				end
			end
			ST_DUTY_START: begin
				div_start = 1'b1;
				div_num   = NUM_W'(thr_q) * NUM_W'(max_duty_q);
				div_den   = DEN_W'(THR_SCALE);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	rpt_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q  <= CLOCK_HZ_RST;
			prescaler_q <= PRESCALER_RST;
			min_duty_q  <= MIN_DUTY_RST;
			max_duty_q  <= MAX_DUTY_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CLOCK_HZ:  clock_hz_q  <= cfg_data[CLK_W-1:0];
				REG_PRESCALER: prescaler_q <= cfg_data[PRE_W-1:0];
				REG_MIN_DUTY:  min_duty_q  <= cfg_data[DUTY_W-1:0];
				REG_MAX_DUTY:  max_duty_q  <= cfg_data[DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Offset of the clamped width above the minimum, kept for the deadband test.
	always_ff @(posedge clk) begin
		if (accept) begin
			width_q <= THR_W'(width_clamped - WIDTH_MIN);
		end
	end

	// Request sequencer, decoder state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			freq_q      <= '0;
			thr_q       <= '0;
			duty_q      <= '0;
			out_valid_q <= 1'b0;
			throttle_q  <= '0;
			duty_out_q  <= '0;
			frequency_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_t'(command))
							CMD_PERIOD: begin
								if (capture_value == '0) begin
									freq_q  <= FREQ_MAX;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_FREQ;
								end
							end
							CMD_WIDTH: begin
								if (!in_window) begin
									state_q <= ST_DUTY_START;
								end else if (!width_ok || max_duty_q == '0) begin
									thr_q   <= '0;
									state_q <= ST_DUTY_START;
								end else begin
									state_q <= ST_DEADBAND;
								end
							end
							CMD_TIMEOUT: begin
								thr_q   <= '0;
								duty_q  <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_FREQ: begin
					if (div_done) begin
						freq_q  <= (div_quo > NUM_W'(FREQ_MAX)) ? FREQ_MAX : div_quo[FREQ_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DEADBAND: begin
					// Widths below the start-duty deadband give zero throttle.
					if (div_done) begin
						thr_q   <= (NUM_W'(width_q) < div_quo) ? '0 : width_q;
						state_q <= ST_DUTY_START;
					end
				end
				ST_DUTY_START: begin
					state_q <= ST_DUTY;
				end
				ST_DUTY: begin
					if (div_done) begin
						duty_q  <= div_quo[DUTY_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						throttle_q  <= thr_q;
						duty_out_q  <= duty_q;
						frequency_q <= freq_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign throttle  = throttle_q;
	assign duty      = duty_out_q;
	assign frequency = frequency_q;

endmodule

// ===== src/rpt_div.sv =====
// Restoring divider that resolves one quotient bit per cycle.
module rpt_div
	import rpt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W+1:0] trial;
	logic             fits;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial = {1'b0, rem_q, quo_q[NUM_W-1]} - {2'b00, den_q};
		fits  = ~trial[DEN_W+1];
	end

	// Dividend bits leave at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DEN_W-1:0] : {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== src/rpt_chk.sv =====
// Port-level checks for the RC PWM throttle decoder and their binding.
module rpt_chk
	import rpt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [THR_W-1:0]  throttle,
	input logic [DUTY_W-1:0] duty
);

	// A stalled result stays on offer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Each request is worked on alone, so the input stalls right after it.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a request");

	// Throttle never exceeds full scale.
	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> throttle <= THR_SCALE)
		else $error("throttle above full scale");

	// Zero throttle always comes with zero duty.
	a_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && throttle == '0 |-> duty == '0)
		else $error("duty nonzero at zero throttle");

endmodule

bind rc_pwm_throttle_decoder rpt_chk u_rpt_chk (.*);
